// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the sponge hash block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/sponge_pkg.sv
// Package: constants, command types and lane reset values of the sponge hash block.
package sponge_pkg;

  localparam int unsigned LANE_W  = 64;
  localparam int unsigned HALF_W  = 32;
  localparam int unsigned NOISE_W = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned TDATA_W = 96;  // 64 + 32, already whole bytes

  localparam logic [LANE_W-1:0] ROUND_STEP = 64'h9E3779B97F4A7C15;

  localparam logic [LANE_W-1:0] LANE_INIT_0 = 64'h534D545F110B3A1D;
  localparam logic [LANE_W-1:0] LANE_INIT_1 = 64'hCBF29CE484222325;
  localparam logic [LANE_W-1:0] LANE_INIT_2 = 64'h00000100000001B3;
  localparam logic [LANE_W-1:0] LANE_INIT_3 = 64'h9999999999999999;

  // Which product of x^5 the multiplier works on.
  typedef enum logic [1:0] {
    MUL_SQ,  // t * t
    MUL_QU,  // sq * sq
    MUL_P5   // qu * t
  } mul_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     absorb;    // fold token and noise in, bump the counter
    logic     rc_init;   // round constant = step
    logic     rc_step;   // round constant += step
    logic     add_rc;    // t = lane + round constant
    mul_sel_e mul_sel;   // operand selection for the multiply
    logic     mul_part;  // register the 32x32 partial products
    logic     mul_sum;   // combine partial products into x
    logic     mix;       // lane = x ^ xor of all x
    logic     load_out;  // copy lane 0 and counter to the output register
  } dp_cmd_t;

  // Reset value of lane idx; lanes past the fourth start at zero.
  function automatic logic [LANE_W-1:0] lane_init(input int unsigned idx);
    logic [LANE_W-1:0] val;
    val = '0;
    if (idx == 0) val = LANE_INIT_0;
    else if (idx == 1) val = LANE_INIT_1;
    else if (idx == 2) val = LANE_INIT_2;
    else if (idx == 3) val = LANE_INIT_3;
    return val;
  endfunction

endpackage

// File: rtl/sponge_ctrl.sv
// Controller: sequences absorb, rounds of add/multiply/mix, and the result handoff.
module sponge_ctrl #(
  parameter int unsigned ROUNDS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output sponge_pkg::dp_cmd_t cmd_o
);
  import sponge_pkg::*;

  localparam int unsigned RND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUNDS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_MULP,
    ST_MULS,
    ST_MIX,
    ST_EMIT
  } state_e;

  state_e           state_q, state_d;
  mul_sel_e         mul_q, mul_d;
  logic [RND_W-1:0] rnd_q, rnd_d;
  logic             mvalid_q, mvalid_d;
  logic             out_free;

  assign out_free      = !mvalid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = mvalid_q;

  // Next state and command decode
  always_comb begin
    state_d  = state_q;
    mul_d    = mul_q;
    rnd_d    = rnd_q;
    mvalid_d = mvalid_q && !m_axis_tready;
    cmd_o    = '{default: '0, mul_sel: mul_q};
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.absorb  = 1'b1;
          cmd_o.rc_init = 1'b1;
          rnd_d         = '0;
          state_d       = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd_o.add_rc = 1'b1;
        mul_d        = MUL_SQ;
        state_d      = ST_MULP;
      end
      ST_MULP: begin
        cmd_o.mul_part = 1'b1;
        state_d        = ST_MULS;
      end
      ST_MULS: begin
        cmd_o.mul_sum = 1'b1;
        unique case (mul_q)
          MUL_SQ: begin
            mul_d   = MUL_QU;
            state_d = ST_MULP;
          end
          MUL_QU: begin
            mul_d   = MUL_P5;
            state_d = ST_MULP;
          end
          default: state_d = ST_MIX;
        endcase
      end
      ST_MIX: begin
        cmd_o.mix     = 1'b1;
        cmd_o.rc_step = 1'b1;
        if (rnd_q == LAST_RND) begin
          state_d = ST_EMIT;
        end else begin
          rnd_d   = rnd_q + RND_W'(1);
          state_d = ST_ADD;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          mvalid_d       = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mul_q    <= MUL_SQ;
      rnd_q    <= '0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mul_q    <= mul_d;
      rnd_q    <= rnd_d;
      mvalid_q <= mvalid_d;
    end
  end

endmodule

// File: rtl/sponge_dp.sv
// Datapath: lane state, per-lane split 64-bit multiplier, mix and output register.
module sponge_dp #(
  parameter int unsigned LANES = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sponge_pkg::dp_cmd_t               cmd_i,
  input  logic [sponge_pkg::LANE_W-1:0]     token_i,
  input  logic [sponge_pkg::NOISE_W-1:0]    noise_i,
  output logic [sponge_pkg::LANE_W-1:0]     hash_o,
  output logic [sponge_pkg::CNT_W-1:0]      count_o
);
  import sponge_pkg::*;

  logic [LANE_W-1:0] lanes_q [LANES];
  logic [LANE_W-1:0] t_q     [LANES];
  logic [LANE_W-1:0] x_q     [LANES];
  logic [LANE_W-1:0] pp_ll_q [LANES];
  logic [HALF_W-1:0] pp_lh_q [LANES];
  logic [HALF_W-1:0] pp_hl_q [LANES];
  logic [LANE_W-1:0] op_a    [LANES];
  logic [LANE_W-1:0] op_b    [LANES];
  logic [LANE_W-1:0] rc_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [LANE_W-1:0] hash_q;
  logic [CNT_W-1:0]  cnt_out_q;
  logic [LANE_W-1:0] mix_all;

  // Multiplier operand selection per lane
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      case (cmd_i.mul_sel)
        MUL_QU: begin
          op_a[i] = x_q[i];
          op_b[i] = x_q[i];
        end
        MUL_P5: begin
          op_a[i] = x_q[i];
          op_b[i] = t_q[i];
        end
        default: begin
          op_a[i] = t_q[i];
          op_b[i] = t_q[i];
        end
      endcase
    end
  end

  // XOR of all lanes after the power step
  always_comb begin
    mix_all = '0;
    for (int i = 0; i < LANES; i++) mix_all = mix_all ^ x_q[i];
  end

  // Lane state and absorption counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANES; i++) lanes_q[i] <= lane_init(i);
      cnt_q <= '0;
    end else begin
      if (cmd_i.absorb) begin
        lanes_q[0] <= lanes_q[0] ^ token_i;
        lanes_q[1] <= lanes_q[1] ^ LANE_W'(noise_i);
        cnt_q      <= cnt_q + CNT_W'(1);
      end else if (cmd_i.mix) begin
        for (int i = 0; i < LANES; i++) lanes_q[i] <= x_q[i] ^ mix_all;
      end
    end
  end

  // Round constant, multiply pipeline and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.rc_init) rc_q <= ROUND_STEP;
    else if (cmd_i.rc_step) rc_q <= rc_q + ROUND_STEP;

    for (int i = 0; i < LANES; i++) begin
      if (cmd_i.add_rc) t_q[i] <= lanes_q[i] + rc_q;
      if (cmd_i.mul_part) begin
        pp_ll_q[i] <= LANE_W'(op_a[i][HALF_W-1:0]) * LANE_W'(op_b[i][HALF_W-1:0]);
        pp_lh_q[i] <= op_a[i][HALF_W-1:0] * op_b[i][LANE_W-1:HALF_W];
        pp_hl_q[i] <= op_a[i][LANE_W-1:HALF_W] * op_b[i][HALF_W-1:0];
      end
      if (cmd_i.mul_sum) begin
        x_q[i] <= pp_ll_q[i] + {pp_lh_q[i] + pp_hl_q[i], {HALF_W{1'b0}}};
      end
    end

    if (cmd_i.load_out) begin
      hash_q    <= lanes_q[0];
      cnt_out_q <= cnt_q;
    end
  end

  assign hash_o  = hash_q;
  assign count_o = cnt_out_q;

endmodule

// File: rtl/sponge_hash_absorb_permute_top.sv
// Sponge absorb-and-permute block: each input transaction is absorbed into
// LANES 64-bit lanes, followed by ROUNDS rounds of add-constant, fifth power
// and XOR mix; one result transaction (lane 0, absorption count) comes back.
// Each round is an add step, three 64-bit multiplies, each a partial-product
// step on the per-lane 32x32 partial-product multipliers and a sum step, and
// a mix step; after the last round the output register is loaded. Items are
// processed one at a time: a new item is not accepted before the previous
// result sits in the output register, but it is accepted as soon as it does,
// in that same cycle, even if that result has not been taken yet.
// A result left waiting stalls the block in its load state, and the input
// stays blocked until the output register frees.
`include "assert_macros.svh"

module sponge_hash_absorb_permute_top #(
  parameter int unsigned ROUNDS = 8,
  parameter int unsigned LANES  = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sponge_pkg::TDATA_W-1:0] s_axis_tdata,  // token[63:0], noise_micro[95:64]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [sponge_pkg::TDATA_W-1:0] m_axis_tdata   // hash_out[63:0], absorb_count[95:64]
);
  import sponge_pkg::*;

  dp_cmd_t           cmd;
  logic [LANE_W-1:0] hash;
  logic [CNT_W-1:0]  count;

  sponge_ctrl #(
    .ROUNDS (ROUNDS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd)
  );

  sponge_dp #(
    .LANES (LANES)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .token_i (s_axis_tdata[LANE_W-1:0]),
    .noise_i (s_axis_tdata[LANE_W+NOISE_W-1:LANE_W]),
    .hash_o  (hash),
    .count_o (count)
  );

  assign m_axis_tdata = {count, hash};

  // Checks
  `ASSERT_HOLDS(a_accept_absorbs, (s_axis_tvalid && s_axis_tready) |-> cmd.absorb, "accepted transaction not absorbed")
  `ASSERT_HOLDS(a_load_slot_free, cmd.load_out |-> (!m_axis_tvalid || m_axis_tready), "result overwrites pending output")
  `ASSERT_HOLDS(a_load_shows, cmd.load_out |=> m_axis_tvalid, "loaded result not presented")
  `ASSERT_NEVER(a_absorb_mix, cmd.absorb && (cmd.mix || cmd.mul_part || cmd.mul_sum), "absorb during a round")

endmodule
